/* rtl/kis_pkg.sv */
`timescale 1ns / 1ps

package kis_pkg;

    localparam int MAX_KEYS_DEF = 256;
    localparam int COUNT_W      = 9;
    localparam int FRAC_ONE     = 65536;

    typedef struct packed {
        logic        kind;
        logic [7:0]  key_index;
        logic [15:0] key_time;
        logic [23:0] query_time;
        logic [7:0]  start_hint;
    } kis_item_t;

    typedef struct packed {
        logic [7:0]  from_index;
        logic [7:0]  to_index;
        logic [16:0] fraction;
    } kis_result_t;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

/* rtl/keyframe_interval_search_core.sv */
`timescale 1ns / 1ps
// A key write is taken with no result and busy low, so writes go back to back.
// A query checks the hinted window, searches with a table read and a compare per probe (at most
// 9 probes), settles the pair and reads its keys, and runs the one-bit-per-cycle divider when a
// fraction needs it; done shows the result for one cycle, and the next item may follow in the
// cycle after. Busy blocks new items meanwhile; the single read port and divider serve one query.
// Reset clears control state and sets key_count to 2, not the key table; done is never stalled.

module keyframe_interval_search_core
    import kis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  kis_item_t   item,
    output logic        done,
    output kis_result_t result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The index and count widths are sized for a table of at most 256 keys.
    localparam int MAX_KEYS = MAX_KEYS_DEF;
    localparam int AW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_HI, S_LO, S_CHK, S_LOOP, S_CMP, S_NXT,
        S_RDF, S_RDT, S_FR, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration register. Write it only while the block is idle; the block does not enforce this.
    logic [COUNT_W-1:0] key_count_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-COUNT_W){1'b0}}, key_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= COUNT_W'(2);
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            key_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Search state. Indices are signed so that hi can drop to -1.
    logic signed [9:0] lo_reg, hi_reg, mid_reg, last_reg, n_reg;
    logic [23:0]       t_reg;
    logic [7:0]        from_reg, to_reg;
    logic [16:0]       frac_reg;
    logic [15:0]       ft_reg;

    logic        accept;
    logic        wr_ok;
    logic [15:0] rdata;
    logic [AW-1:0] raddr;
    logic signed [9:0] rd_idx;
    logic [23:0] key_fx;

    logic signed [9:0] n_c, last_c, lo_c, hi_c;

    logic [24:0] num_c;
    logic [16:0] diff_c;
    logic [23:0] span_c;
    logic        div_go;
    logic        div_ready;
    logic [15:0] div_q;

    assign accept = start && !busy;
    assign wr_ok  = accept && item.kind == KIND_WRITE && 32'(item.key_index) < MAX_KEYS;
    assign key_fx = {rdata, 8'd0};

    always_comb
    begin
        if (32'(key_count_reg) < 2)
        begin
            n_c = 10'sd2;
        end
        else if (32'(key_count_reg) > MAX_KEYS)
        begin
            n_c = 10'(MAX_KEYS);
        end
        else
        begin
            n_c = $signed({1'b0, key_count_reg});
        end
        last_c = n_c - 10'sd1;
        lo_c   = $signed({2'b0, item.start_hint});
        if (lo_c > last_c)
        begin
            lo_c = last_c;
        end
        hi_c = lo_c + 10'sd1;
        if (hi_c > last_c)
        begin
            hi_c = last_c;
        end
    end

    // Table read address for the state that issues a read.
    always_comb
    begin
        case (state_reg)
            S_HI:    rd_idx = hi_reg;
            S_LO:    rd_idx = lo_reg;
            S_LOOP:  rd_idx = (lo_reg <= hi_reg) ? ((lo_reg + hi_reg) >>> 1)
                                                 : (hi_reg + 10'sd1);
            S_RDF:   rd_idx = $signed({2'b0, from_reg});
            S_RDT:   rd_idx = $signed({2'b0, to_reg});
            default: rd_idx = '0;
        endcase
        raddr = AW'($unsigned(rd_idx));
    end

    // Fraction operands once key[to] arrives; ft_reg holds key[from].
    always_comb
    begin
        num_c  = {1'b0, t_reg} - {1'b0, ft_reg, 8'd0};
        diff_c = {1'b0, rdata} - {1'b0, ft_reg};
        span_c = diff_c[16] ? {(16'd0 - diff_c[15:0]), 8'd0} : {diff_c[15:0], 8'd0};
        div_go = state_reg == S_FR && span_c != 24'd0 && !num_c[24]
                 && num_c[23:0] < span_c;
    end

    kis_key_ram #(.MAX_KEYS(MAX_KEYS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (AW'(item.key_index)),
        .wdata (item.key_time),
        .raddr (raddr),
        .rdata (rdata)
    );

    kis_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (num_c[23:0]),
        .span  (span_c),
        .ready (div_ready),
        .quot  (div_q)
    );

    // One query at a time walks the table through the single read port, so
    // no two accesses to the same entry can overlap; busy is the interlock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && item.kind == KIND_QUERY)
                    begin
                        n_reg     <= n_c;
                        last_reg  <= last_c;
                        lo_reg    <= lo_c;
                        hi_reg    <= hi_c;
                        t_reg     <= item.query_time;
                        state_reg <= S_HI;
                    end
                end
                S_HI:
                begin
                    state_reg <= S_LO;
                end
                S_LO:
                begin
                    if (key_fx < t_reg)
                    begin
                        hi_reg <= last_reg;
                    end
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (key_fx > t_reg)
                    begin
                        lo_reg <= '0;
                    end
                    state_reg <= S_LOOP;
                end
                S_LOOP:
                begin
                    if (lo_reg <= hi_reg)
                    begin
                        mid_reg   <= rd_idx;
                        state_reg <= S_CMP;
                    end
                    else if (hi_reg >= 0 && hi_reg + 10'sd1 < n_reg)
                    begin
                        state_reg <= S_NXT;
                    end
                    else
                    begin
                        from_reg  <= last_reg[7:0];
                        to_reg    <= last_reg[7:0];
                        frac_reg  <= 17'(FRAC_ONE);
                        state_reg <= S_OUT;
                    end
                end
                S_CMP:
                begin
                    if (key_fx == t_reg)
                    begin
                        if (mid_reg == last_reg)
                        begin
                            from_reg  <= last_reg[7:0];
                            to_reg    <= last_reg[7:0];
                            frac_reg  <= 17'(FRAC_ONE);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            from_reg  <= mid_reg[7:0];
                            to_reg    <= 8'(mid_reg + 10'sd1);
                            state_reg <= S_RDF;
                        end
                    end
                    else if (key_fx > t_reg)
                    begin
                        hi_reg    <= mid_reg - 10'sd1;
                        state_reg <= S_LOOP;
                    end
                    else
                    begin
                        lo_reg    <= mid_reg + 10'sd1;
                        state_reg <= S_LOOP;
                    end
                end
                S_NXT:
                begin
                    if (key_fx > t_reg)
                    begin
                        from_reg  <= hi_reg[7:0];
                        to_reg    <= 8'(hi_reg + 10'sd1);
                        state_reg <= S_RDF;
                    end
                    else
                    begin
                        from_reg  <= last_reg[7:0];
                        to_reg    <= last_reg[7:0];
                        frac_reg  <= 17'(FRAC_ONE);
                        state_reg <= S_OUT;
                    end
                end
                S_RDF:
                begin
                    state_reg <= S_RDT;
                end
                S_RDT:
                begin
                    ft_reg    <= rdata;
                    state_reg <= S_FR;
                end
                S_FR:
                begin
                    // Zero span and a fraction of one or more saturate to one; a time before key[from] gives zero.
                    if (span_c == 24'd0)
                    begin
                        frac_reg  <= 17'(FRAC_ONE);
                        state_reg <= S_OUT;
                    end
                    else if (num_c[24])
                    begin
                        frac_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (num_c[23:0] >= span_c)
                    begin
                        frac_reg  <= 17'(FRAC_ONE);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_ready)
                    begin
                        frac_reg  <= {1'b0, div_q};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = state_reg != S_IDLE;
    assign done              = state_reg == S_OUT;
    assign result.from_index = from_reg;
    assign result.to_index   = to_reg;
    assign result.fraction   = frac_reg;

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result beat longer than one cycle");

    a_write_no_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind == KIND_WRITE) |=> !busy && !done)
        else $error("key write must not start a search");

    a_frac_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.fraction <= 17'(FRAC_ONE))
        else $error("fraction above one");

    a_pair : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.to_index == result.from_index
                  || result.to_index == result.from_index + 8'd1))
        else $error("indices do not form a bracketing pair");

endmodule

/* rtl/kis_key_ram.sv */
`timescale 1ns / 1ps

module kis_key_ram
    import kis_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF,
    parameter int AW       = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    // Key time table; contents are undefined until written.
    logic [15:0] mem [MAX_KEYS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/kis_frac_div.sv */
`timescale 1ns / 1ps

module kis_frac_div
    import kis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [23:0] num,
    input  logic [23:0] span,
    output logic        ready,
    output logic [15:0] quot
);

    // Restoring division of num * 2^16 by span, one quotient bit per cycle.
    // The caller guarantees num < span, so the quotient fits in 16 bits.
    logic [23:0] rem_reg, rem_next;
    logic [23:0] span_reg;
    logic [15:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        ready_reg;
    logic [24:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        rem_next  = shifted[23:0];
        quot_next = {quot_reg[14:0], 1'b0};
        if (shifted >= {1'b0, span_reg})
        begin
            rem_next  = 24'(shifted - {1'b0, span_reg});
            quot_next = {quot_reg[14:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            ready_reg <= 1'b0;
            if (go)
            begin
                run_reg  <= 1'b1;
                cnt_reg  <= 5'd16;
                rem_reg  <= num;
                span_reg <= span;
                quot_reg <= '0;
            end
            else if (run_reg)
            begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg   <= 1'b0;
                    ready_reg <= 1'b1;
                end
            end
        end
    end

    assign ready = ready_reg;
    assign quot  = quot_reg;

endmodule

/* tb/sv/keyframe_interval_search_checker.sv */
`timescale 1ns / 1ps

module keyframe_interval_search_checker
    import kis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  kis_item_t   item,
    input  logic        done,
    input  kis_result_t result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          query_beats,
    output int          write_beats
);

    logic [15:0]  key_table [0:255];
    logic [8:0]   key_count;
    kis_result_t  expected_q [$];

    function automatic logic [16:0] interp_fraction(input longint t, input int from_i,
                                                     input int to_i);
        longint ft;
        longint span;
        longint num;
        longint q;
        ft   = longint'(key_table[from_i]) * 256;
        span = longint'(key_table[to_i]) * 256 - ft;
        num  = t - ft;
        if (span < 0)
            span = -span;
        if (span == 0)
            return 17'd65536;
        if (num < 0)
            return 17'd0;
        q = (num << 16) / span;
        return (q > 65536) ? 17'd65536 : q[16:0];
    endfunction

    function automatic kis_result_t locate_interval(input kis_item_t it);
        int          n;
        int          last;
        int          lo;
        int          hi;
        int          mid;
        int          from_i;
        int          to_i;
        bit          tail;
        longint      t;
        kis_result_t r;
        from_i = -1;
        to_i   = 0;
        tail   = 0;
        n = key_count;
        if (n < 2)
            n = 2;
        if (n > 256)
            n = 256;
        last = n - 1;
        t  = it.query_time;
        lo = it.start_hint;
        if (lo > last)
            lo = last;
        hi = lo + 1;
        if (hi > last)
            hi = last;
        if (longint'(key_table[hi]) * 256 < t)
            hi = last;
        if (longint'(key_table[lo]) * 256 > t)
            lo = 0;
        while (lo <= hi) begin
            mid = (lo + hi) >> 1;
            if (longint'(key_table[mid]) * 256 == t) begin
                if (mid == last)
                    tail = 1;
                else begin
                    from_i = mid;
                    to_i   = mid + 1;
                end
                break;
            end
            if (longint'(key_table[mid]) * 256 > t)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        if (from_i < 0 && !tail && hi >= 0 && hi + 1 < n
            && longint'(key_table[hi + 1]) * 256 > t) begin
            from_i = hi;
            to_i   = hi + 1;
        end
        if (from_i >= 0)
            r.fraction = interp_fraction(t, from_i, to_i);
        else begin
            from_i     = last;
            to_i       = last;
            r.fraction = 17'd65536;
        end
        r.from_index = from_i[7:0];
        r.to_index   = to_i[7:0];
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        kis_result_t exp_r;
        if (!rst_n) begin
            key_count   <= 9'd2;
            fail_count  <= 0;
            query_beats <= 0;
            write_beats <= 0;
            expected_q.delete();
        end
        else begin
            // The result check comes first: a result beat can never answer the item
            // accepted at the same edge.
            if (done) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, result);
                    fail_count <= fail_count + 1;
                end
                else begin
                    exp_r = expected_q.pop_front();
                    if (result.from_index !== exp_r.from_index
                        || result.to_index !== exp_r.to_index
                        || result.fraction !== exp_r.fraction) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, exp_r, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                if (item.kind == KIND_WRITE) begin
                    key_table[item.key_index] = item.key_time;
                    write_beats <= write_beats + 1;
                end
                else begin
                    expected_q.push_back(locate_interval(item));
                    query_beats <= query_beats + 1;
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
                key_count <= pwdata[8:0];
        end
    end

endmodule

/* tb/sv/keyframe_interval_search_core_tb.sv */
`timescale 1ns / 1ps

module keyframe_interval_search_core_tb;
    import kis_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    kis_item_t   item;
    logic        done;
    kis_result_t result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int query_beats;
    int write_beats;
    int idle_cycles;

    // The testbench's own view of the key count, used to keep every query
    // inside the written part of the table.
    int active_keys;

    // Every query ends in a result beat and the sender's gap is bounded, so
    // STALL_LIMIT idle cycles in a row mean the block has hung.
    localparam int STALL_LIMIT = 2000;

    keyframe_interval_search_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    keyframe_interval_search_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .pending     (pending),
        .query_beats (query_beats),
        .write_beats (write_beats)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // The watchdog counts cycles in which neither an item nor a result beat
    // moves, and ends the run when the block stops making progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("keyframe_interval_search_core_tb: errors");
            $finish;
        end
    end

    // Sends one item after a random gap, if allow_gap is set, and holds start
    // until the block accepts it. Start stays high between back-to-back items
    // and is dropped by the gap of the next item or by drain.
    task automatic send_beat(input kis_item_t it, input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_key(input int idx, input int value, input bit allow_gap);
        kis_item_t it;
        it            = '0;
        it.kind       = KIND_WRITE;
        it.key_index  = idx[7:0];
        it.key_time   = value[15:0];
        it.query_time = 24'($urandom());
        it.start_hint = 8'($urandom());
        send_beat(it, allow_gap);
    endtask

    task automatic query_time_at(input int qt, input int hint, input bit allow_gap);
        kis_item_t it;
        it            = '0;
        it.kind       = KIND_QUERY;
        it.key_index  = 8'($urandom());
        it.key_time   = 16'($urandom());
        it.query_time = qt[23:0];
        it.start_hint = hint[7:0];
        send_beat(it, allow_gap);
    endtask

    // Waits until every expected result has arrived, then lets the longest
    // query latency pass so nothing is still in flight.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // APB write: a setup phase, then an access phase in which the register
    // is written since pready is always high.
    task automatic write_key_count(input int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_keys = (value < 2) ? 2 : ((value > 256) ? 256 : value);
    endtask

    // Fills the first fill_n entries with an ascending ramp of random steps;
    // repeated times are left in on purpose so zero spans come up. A few
    // entries may be made unsorted when shuffle is set.
    task automatic fill_table(input int max_step, input bit shuffle, input int fill_n);
        int acc;
        acc = $urandom_range(0, 40);
        for (int k = 0; k < fill_n; k++) begin
            if (shuffle && $urandom_range(0, 15) == 0)
                write_key(k, $urandom_range(0, 65535), 1'b1);
            else
                write_key(k, acc, 1'b1);
            acc = acc + $urandom_range(0, max_step);
            if (acc > 65535)
                acc = 65535;
        end
    endtask

    int key_shadow [0:255];

    // A random query aimed mostly near real keys; the hint is mostly inside the
    // active table, but any hint may come.
    task automatic random_query();
        int k;
        int qt;
        int hint;
        int sel;
        k   = $urandom_range(0, active_keys - 1);
        sel = $urandom_range(0, 9);
        case (sel)
            0: qt = key_shadow[k] * 256;
            1: qt = $urandom_range(0, 24'hFFFFFF);
            2: qt = 0;
            3: qt = 24'hFFFFFF;
            default: qt = key_shadow[k] * 256 + $urandom_range(0, 2047) - 256;
        endcase
        if (qt < 0)
            qt = 0;
        if (qt > 24'hFFFFFF)
            qt = 24'hFFFFFF;
        hint = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(0, active_keys - 1);
        query_time_at(qt, hint, $urandom_range(0, 3) != 0);
    endtask

    initial
    begin
        start   <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'd0;
        pwdata  <= 32'd0;
        active_keys = 2;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a four-key table with a repeated time for the zero
        // span, then exact hits, the edges, a large hint and an out-of-range count.
        write_key(0, 0, 1'b0);
        write_key(1, 10, 1'b0);
        write_key(2, 10, 1'b0);
        write_key(3, 65535, 1'b0);
        query_time_at(128, 0, 1'b0);            // inside the reset two-key table
        write_key_count(4);
        query_time_at(0, 0, 1'b0);              // exact hit on the first key
        query_time_at(10 * 256, 0, 1'b0);       // exact hit, zero span pair
        query_time_at(5 * 256 + 7, 3, 1'b0);    // hint past the time
        query_time_at(24'hFFFF00, 0, 1'b0);     // exact hit on the last key
        query_time_at(24'hFFFFFF, 255, 1'b0);   // after the last key, hint clamped
        query_time_at(40000 * 256, 1, 1'b1);    // hint below the time
        write_key(0, 5, 1'b0);
        query_time_at(4 * 256, 2, 1'b0);        // before the first key
        write_key(1, 2, 1'b0);                  // unsorted pair
        query_time_at(6 * 256, 0, 1'b0);
        write_key_count(0);                     // saturates to two keys
        query_time_at(3 * 256, 0, 1'b0);
        write_key_count(511);                   // saturates to the full table count
        write_key_count(4);

        // Random phases over several table shapes and counts, extremes included.
        // The first phase writes the whole table, so later phases rewrite only
        // the keys that they use.
        for (int phase = 0; phase < 6; phase++) begin
            int count;
            int fill_n;
            case (phase)
                0: count = 256;
                1: count = 2;
                2: count = 300;
                default: count = $urandom_range(2, 64);
            endcase
            fill_n = (count > 256) ? 0 : count;
            if (fill_n > 0)
                fill_table((phase == 3) ? 3 : 400, phase == 4, fill_n);
            write_key_count(count);
            for (int j = 0; j < 90; j++) begin
                random_query();
                // Rewrite a key in place now and then; the table stays written.
                if ($urandom_range(0, 19) == 0)
                    write_key($urandom_range(0, 255), $urandom_range(0, 65535), 1'b1);
            end
            // One pause per phase until every expected result has come.
            drain();
        end

        drain();
        $display("covered %0d key writes and %0d queries over six table shapes",
                 write_beats, query_beats);
        $display("key counts from the saturated minimum to the full table, any hint");
        if (fail_count == 0)
            $display("keyframe_interval_search_core_tb: clean");
        else
            $display("keyframe_interval_search_core_tb: errors");
        $finish;
    end

    // The shadow copy of key times follows every accepted write, so query
    // targets land near keys as they stand.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy && item.kind == KIND_WRITE)
            key_shadow[item.key_index] <= item.key_time;
    end

endmodule

/* files.f */
rtl/kis_pkg.sv
rtl/kis_key_ram.sv
rtl/kis_frac_div.sv
rtl/keyframe_interval_search_core.sv
tb/sv/keyframe_interval_search_checker.sv
tb/sv/keyframe_interval_search_core_tb.sv
